>>> hw/rtl/sorted_priority_queue_top_macros.svh
// Assertion macros for the sorted priority queue top level
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// clocked assertion, suspended while reset is asserted
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hw/rtl/spq_pkg.sv
// Types and constants of the sorted priority queue
`default_nettype none

package spq_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PRIO_W  = 16;
  localparam int unsigned TOTAL_W = 5;
  localparam int unsigned STAT_W  = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

  // one slot of the sorted row
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] prio;
  } ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/spq_cell.sv
// One slot of the sorted row: holds an entry and trades it with its neighbors
`default_nettype none

module spq_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire spq_pkg::ctrl_t  ctrl_i,
  input  wire spq_pkg::entry_t prev_i,     // slot closer to the head
  input  wire logic            prev_gt_i,  // that slot moves down on this insert
  input  wire spq_pkg::entry_t next_i,     // slot farther from the head
  output spq_pkg::entry_t      entry_o,
  output logic                 gt_o
);

  logic                       valid_q;
  logic [spq_pkg::DATA_W-1:0] data_q;
  logic [spq_pkg::PRIO_W-1:0] prio_q;
  spq_pkg::entry_t            entry_d;
  logic                       load;

  // strictly greater: equal priorities keep arrival order
  assign gt_o = valid_q && ($signed(prio_q) > $signed(ctrl_i.prio));

  assign entry_o = '{valid: valid_q, data: data_q, prio: prio_q};

  always_comb begin
    entry_d = entry_o;
    load    = 1'b0;
    if (ctrl_i.ins) begin
      if (prev_gt_i) begin
        entry_d = prev_i;
        load    = 1'b1;
      end else if (gt_o || (!valid_q && prev_i.valid)) begin
        entry_d = '{valid: 1'b1, data: ctrl_i.data, prio: ctrl_i.prio};
        load    = 1'b1;
      end
    end else if (ctrl_i.rem) begin
      entry_d = next_i;
      load    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= entry_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= entry_d.data;
      prio_q <= entry_d.prio;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: cell row, fill count, result register
//
//  channel  dir  tdata (low bit up)                         tuser
//  s_axis   in   data_value[31:0] priority_req[47:32]       command[0]
//  m_axis   out  out_data[31:0] out_priority[47:32]         status[1:0]
//                entry_total[52:48], zero pad to 56 bits
//
// One transaction per cycle; its result appears in the output register the
// next cycle. Every cell compares against the new priority in parallel and
// shifts in one step, so the row itself never stalls the input.
// s_axis_tready drops only while a result waits and m_axis_tready is low.
// Reset clears the slot valid bits, the fill count and the output valid flag.
`default_nettype none

module sorted_priority_queue_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // data_value[31:0], priority_req[47:32]
  input  wire logic [0:0]  s_axis_tuser,   // command[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // out_data[31:0], out_priority[47:32],
                                           // entry_total[52:48]
  output logic [1:0]       m_axis_tuser    // status[1:0]
);

  `include "sorted_priority_queue_top_macros.svh"

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  spq_pkg::ctrl_t  ctrl;
  spq_pkg::entry_t entries [CAPACITY];
  logic            gts     [CAPACITY];
  logic [CAPACITY-1:0] vld;

  logic [CW-1:0] count_q, count_d;
  logic          full, empty, fire, cmd;

  logic                        out_valid_q;
  logic [spq_pkg::STAT_W-1:0]  status_q, status_d;
  logic [spq_pkg::DATA_W-1:0]  odata_q, odata_d;
  logic [spq_pkg::PRIO_W-1:0]  oprio_q, oprio_d;
  logic [spq_pkg::TOTAL_W-1:0] total_q;
  logic [CW+spq_pkg::TOTAL_W-1:0] count_ext;

  assign cmd   = s_axis_tuser[0];
  assign full  = (count_q == CW'(CAPACITY));
  assign empty = (count_q == '0);

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;

  assign ctrl.ins  = fire && (cmd == spq_pkg::CMD_INSERT) && !full;
  assign ctrl.rem  = fire && (cmd == spq_pkg::CMD_REMOVE) && !empty;
  assign ctrl.data = s_axis_tdata[31:0];
  assign ctrl.prio = s_axis_tdata[47:32];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::entry_t prev_e, next_e;
    logic            prev_gt;

    if (i == 0) begin : g_head
      // head sees an always-valid, never-greater slot in front of it
      assign prev_e  = '{valid: 1'b1, data: '0, prio: '0};
      assign prev_gt = 1'b0;
    end else begin : g_mid
      assign prev_e  = entries[i-1];
      assign prev_gt = gts[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_body
      assign next_e = entries[i+1];
    end

    spq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .prev_i    (prev_e),
      .prev_gt_i (prev_gt),
      .next_i    (next_e),
      .entry_o   (entries[i]),
      .gt_o      (gts[i])
    );

    assign vld[i] = entries[i].valid;
  end

  always_comb begin
    count_d  = count_q;
    status_d = spq_pkg::STATUS_OK;
    odata_d  = '0;
    oprio_d  = '0;
    if (cmd == spq_pkg::CMD_INSERT) begin
      if (full) begin
        status_d = spq_pkg::STATUS_FULL;
      end else begin
        count_d = count_q + CW'(1);
      end
    end else begin
      if (empty) begin
        status_d = spq_pkg::STATUS_EMPTY;
      end else begin
        count_d = count_q - CW'(1);
        odata_d = entries[0].data;
        oprio_d = entries[0].prio;
      end
    end
  end

  assign count_ext = {{spq_pkg::TOTAL_W{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q <= count_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      odata_q  <= odata_d;
      oprio_q  <= oprio_d;
      total_q  <= count_ext[spq_pkg::TOTAL_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, total_q, oprio_q, odata_q};
  assign m_axis_tuser  = status_q;

  // fill count tracks the valid bits of the row
  `SPQ_ASSERT(a_count_matches, (CW'($countones(vld)) == count_q), "count mismatch")
  // occupied slots form an unbroken run from the head
  `SPQ_ASSERT(a_valid_packed, ((vld & (vld + CAPACITY'(1))) == '0), "gap in row")
  `SPQ_ASSERT(a_count_bound, (count_q <= CW'(CAPACITY)), "count above capacity")
  `SPQ_ASSERT(a_remove_dec, (ctrl.rem |=> (count_q == $past(count_q) - CW'(1))), "remove count")
  `SPQ_ASSERT(a_full_drop, ((fire && full && (cmd == spq_pkg::CMD_INSERT)) |=> $stable(count_q)),
              "drop changed count")

endmodule

`default_nettype wire

>>> test/sorted_priority_queue_top_test.sv
// Self-checking testbench for the sorted priority queue: random bursts, stalls, scoreboard
`timescale 1ns / 1ps

typedef struct packed {
  logic [spq_pkg::STAT_W-1:0]  status;
  logic [spq_pkg::DATA_W-1:0]  data;
  logic [spq_pkg::PRIO_W-1:0]  prio;
  logic [spq_pkg::TOTAL_W-1:0] total;
} spq_result_t;

typedef struct packed {
  logic [spq_pkg::DATA_W-1:0] data;
  logic [spq_pkg::PRIO_W-1:0] prio;
} spq_held_t;

class spq_scoreboard;
  int unsigned   depth;
  spq_held_t     held_entries[$];    // sorted copy of the queue contents, head first
  spq_result_t   pending_results[$];
  int unsigned   mismatches;

  function new(int unsigned depth_i);
    depth = depth_i;
    mismatches = 0;
  endfunction

  function int unsigned pending();
    return pending_results.size();
  endfunction

  // work out the result of one accepted command and queue it
  function void note_command(logic cmd, logic [spq_pkg::DATA_W-1:0] d,
                             logic [spq_pkg::PRIO_W-1:0] p);
    spq_result_t r;
    spq_held_t   e;
    int          pos;
    int unsigned held_n;
    r = '0;
    if (cmd == spq_pkg::CMD_INSERT) begin
      if (held_entries.size() >= depth) begin
        r.status = spq_pkg::STATUS_FULL;
      end else begin
        pos = 0;
        // new entry goes behind every entry of lower or equal priority
        while (pos < held_entries.size() &&
               $signed(held_entries[pos].prio) <= $signed(p)) pos++;
        e.data = d;
        e.prio = p;
        held_entries.insert(pos, e);
        r.status = spq_pkg::STATUS_OK;
      end
    end else begin
      if (held_entries.size() == 0) begin
        r.status = spq_pkg::STATUS_EMPTY;
      end else begin
        e = held_entries.pop_front();
        r.data   = e.data;
        r.prio   = e.prio;
        r.status = spq_pkg::STATUS_OK;
      end
    end
    held_n  = held_entries.size();
    r.total = held_n[spq_pkg::TOTAL_W-1:0];
    pending_results.push_back(r);
  endfunction

  function void flag(string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endfunction

  function void check_result(logic [spq_pkg::STAT_W-1:0] st, logic [55:0] td);
    spq_result_t want;
    spq_result_t got;
    got.status = st;
    got.data   = td[31:0];
    got.prio   = td[47:32];
    got.total  = td[52:48];
    if (pending_results.size() == 0) begin
      flag($sformatf("result with nothing pending: status %0d data %h prio %h total %0d",
                     got.status, got.data, got.prio, got.total));
      return;
    end
    want = pending_results.pop_front();
    if (got.status != want.status)
      flag($sformatf("status exp %0d got %0d", want.status, got.status));
    if (got.data != want.data)
      flag($sformatf("out_data exp %h got %h", want.data, got.data));
    if (got.prio != want.prio)
      flag($sformatf("out_priority exp %h got %h", want.prio, got.prio));
    if (got.total != want.total)
      flag($sformatf("entry_total exp %0d got %0d", want.total, got.total));
  endfunction
endclass

module sorted_priority_queue_top_test;

  localparam int unsigned QUEUE_DEPTH  = 16;
  localparam int unsigned RANDOM_ITEMS = 750;
  localparam int unsigned CYCLE_LIMIT  = 300000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  spq_scoreboard sb = new(QUEUE_DEPTH);
  int unsigned   cycle_count = 0;
  int unsigned   stall_style = 0;

  sorted_priority_queue_top #(.CAPACITY(QUEUE_DEPTH)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // sample both channels on the edge where a transaction completes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_command(s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[47:32]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  // receiver backpressure: one of four stall styles, redrawn at random
  always @(posedge clk_i) begin
    if (cycle_count % 97 == 0) stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (cycle_count % 4 == 0);
      default: m_axis_tready <= ($urandom_range(0, 99) < 85);
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // present one command and hold it until the transaction completes
  task automatic send_cmd(input logic cmd, input logic [31:0] d, input logic [15:0] p);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {p, d};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic idle_cycles(input int unsigned n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_prio();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      1, 2, 3: return 16'($urandom);
      // narrow band so equal priorities are common
      default: return 16'($signed($urandom_range(0, 6)) - 3);
    endcase
  endfunction

  task automatic run_directed();
    send_cmd(spq_pkg::CMD_REMOVE, $urandom, 16'($urandom));  // remove while empty
    send_cmd(spq_pkg::CMD_INSERT, 32'h0000_0000, 16'h0000);
    send_cmd(spq_pkg::CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
    send_cmd(spq_pkg::CMD_INSERT, 32'h8000_0000, 16'h8000);
    send_cmd(spq_pkg::CMD_INSERT, 32'h7FFF_FFFF, 16'h7FFF);
    send_cmd(spq_pkg::CMD_INSERT, 32'h0000_0001, 16'h0000);  // ties keep arrival order
    send_cmd(spq_pkg::CMD_INSERT, 32'h0000_0002, 16'h0000);
    send_cmd(spq_pkg::CMD_INSERT, 32'h0000_0003, 16'h7FFF);
    send_cmd(spq_pkg::CMD_INSERT, 32'h0000_0004, 16'h8000);
    for (int i = 0; i < 8; i++) send_cmd(spq_pkg::CMD_INSERT, $urandom, pick_prio());
    send_cmd(spq_pkg::CMD_INSERT, 32'hAAAA_5555, 16'h8000);  // dropped, queue is full
    for (int i = 0; i < 5; i++) send_cmd(spq_pkg::CMD_REMOVE, $urandom, 16'($urandom));
  endtask

  task automatic run_random();
    int unsigned sent;
    int unsigned burst_left;
    int unsigned seg_left;
    int unsigned mode;
    int unsigned ins_pct;
    logic        cmd;
    sent = 0;
    burst_left = 0;
    seg_left = 0;
    mode = 0;
    while (sent < RANDOM_ITEMS) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 40);
        mode = $urandom_range(0, 2);
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
      end
      // fill-heavy, drain-heavy and balanced stretches reach both full and empty
      ins_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
      cmd = ($urandom_range(0, 99) < ins_pct) ? spq_pkg::CMD_INSERT : spq_pkg::CMD_REMOVE;
      send_cmd(cmd, $urandom, pick_prio());
      sent++;
      burst_left--;
      seg_left--;
    end
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
